>>> sv/lgrs_pkg.sv
`default_nettype none

package lgrs_pkg;

    // width of the row fields on the ports
    localparam int FIELD_W = 40;

    // number of rows held between requests
    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE  = 2'd1;
    localparam logic [1:0] HELD_TWO  = 2'd2;

    // one result row as it waits in the output queue
    typedef struct packed {
        logic [FIELD_W-1:0] cells;
        logic               frame_end;
    } result_t;

    // bits of one column that a cell shows to its neighbors
    typedef struct packed {
        logic above;
        logic middle;
        logic below;
    } col_bits_t;

    // write control into the output queue
    typedef struct packed {
        logic push_a;
        logic push_b;
    } push_t;

    // b3/s23 rule on a live flag and a neighbor count
    function automatic logic life_rule(input logic alive, input logic [3:0] n);
        logic res;
        begin
            res = (n == 4'd3) || (alive && (n == 4'd2));
            return res;
        end
    endfunction

endpackage

`default_nettype wire

>>> sv/life_generation_row_stream.sv
`default_nettype none

// channel  | handshake            | payload
// ---------+----------------------+-------------------------------
// input    | in_valid / in_ready  | row_cells[39:0], last_row
// output   | out_valid / out_ready| next_row_cells[39:0], frame_end
//
// one row request is taken per cycle while in_ready is high; a row of ROW_WIDTH cells computes
// both candidate result rows in the cycle the request is taken.
// results leave through a four-entry queue, registered there, one per cycle
// while out_ready is high; a bottom row can add two, so in_ready drops while
// the queue holds more than two rows.
// reset empties the queue and clears the held rows to all dead.

module life_generation_row_stream
    import lgrs_pkg::*;
#(
    parameter int ROW_WIDTH = 40
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [FIELD_W-1:0] row_cells,
    input  wire logic               last_row,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [FIELD_W-1:0]      next_row_cells,
    output logic                    frame_end
);

    logic [1:0]           held_reg;
    logic [1:0]           held_next;
    logic                 accept;
    logic                 room;
    col_bits_t            col_bits [ROW_WIDTH+2];
    logic [ROW_WIDTH-1:0] gen_a;
    logic [ROW_WIDTH-1:0] gen_b;
    logic [FIELD_W-1:0]   cells_a;
    logic [FIELD_W-1:0]   cells_b;
    push_t                push;
    result_t              data_a;
    result_t              data_b;
    result_t              out_data;

    assign in_ready = room;
    assign accept   = in_valid && room;

    always_comb
    begin
        held_next = held_reg;
        if (accept)
        begin
            if (last_row)
                held_next = HELD_NONE;
            else if (held_reg == HELD_NONE)
                held_next = HELD_ONE;
            else
                held_next = HELD_TWO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= HELD_NONE;
        else
            held_reg <= held_next;
    end

    // columns outside the grid are dead
    assign col_bits[0]           = '0;
    assign col_bits[ROW_WIDTH+1] = '0;

    for (genvar k = 0; k < ROW_WIDTH; k++)
    begin : g_cell
        logic in_bit;
        if (k < FIELD_W)
        begin : g_in
            assign in_bit = row_cells[k];
        end
        else
        begin : g_pad
            assign in_bit = 1'b0;
        end

        lgrs_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift      (accept && !last_row),
            .clear      (accept && last_row),
            .in_bit     (in_bit),
            .left_bits  (col_bits[k]),
            .right_bits (col_bits[k+2]),
            .own_bits   (col_bits[k+1]),
            .gen_a      (gen_a[k]),
            .gen_b      (gen_b[k])
        );
    end

    for (genvar k = 0; k < FIELD_W; k++)
    begin : g_field
        if (k < ROW_WIDTH)
        begin : g_used
            assign cells_a[k] = gen_a[k];
            assign cells_b[k] = gen_b[k];
        end
        else
        begin : g_zero
            assign cells_a[k] = 1'b0;
            assign cells_b[k] = 1'b0;
        end
    end

    // with no row held the middle row is all dead, so the second result
    // covers a single-row frame as well
    assign push.push_a = accept && (held_reg != HELD_NONE);
    assign push.push_b = accept && last_row;

    assign data_a.cells     = cells_a;
    assign data_a.frame_end = 1'b0;
    assign data_b.cells     = cells_b;
    assign data_b.frame_end = 1'b1;

    lgrs_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .data_a    (data_a),
        .data_b    (data_b),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign next_row_cells = out_data.cells;
    assign frame_end      = out_data.frame_end;

endmodule

`default_nettype wire

>>> sv/lgrs_cell.sv
`default_nettype none

module lgrs_cell
    import lgrs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      shift,
    input  wire logic      clear,
    input  wire logic      in_bit,
    input  wire col_bits_t left_bits,
    input  wire col_bits_t right_bits,
    output col_bits_t      own_bits,
    output logic           gen_a,
    output logic           gen_b
);

    logic       above_reg;
    logic       above_next;
    logic       middle_reg;
    logic       middle_next;
    logic [3:0] n_a;
    logic [3:0] n_b;

    always_comb
    begin
        above_next  = above_reg;
        middle_next = middle_reg;
        if (clear)
        begin
            above_next  = 1'b0;
            middle_next = 1'b0;
        end
        else if (shift)
        begin
            above_next  = middle_reg;
            middle_next = in_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            above_reg  <= 1'b0;
            middle_reg <= 1'b0;
        end
        else
        begin
            above_reg  <= above_next;
            middle_reg <= middle_next;
        end
    end

    assign own_bits.above  = above_reg;
    assign own_bits.middle = middle_reg;
    assign own_bits.below  = in_bit;

    // held middle row, with the incoming row below
    assign n_a = 4'(left_bits.above) + 4'(above_reg) + 4'(right_bits.above)
               + 4'(left_bits.middle) + 4'(right_bits.middle)
               + 4'(left_bits.below) + 4'(in_bit) + 4'(right_bits.below);

    // incoming row as the bottom row, dead row below
    assign n_b = 4'(left_bits.middle) + 4'(middle_reg) + 4'(right_bits.middle)
               + 4'(left_bits.below) + 4'(right_bits.below);

    assign gen_a = life_rule(middle_reg, n_a);
    assign gen_b = life_rule(in_bit, n_b);

endmodule

`default_nettype wire

>>> sv/lgrs_out_queue.sv
`default_nettype none

module lgrs_out_queue
    import lgrs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire push_t   push,
    input  wire result_t data_a,
    input  wire result_t data_b,
    output logic         room,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    localparam int DEPTH  = 4;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = PTR_W + 1;
    localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - 2);

    result_t           entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  n_push;
    logic              pop;
    result_t           first_data;

    assign n_push     = CNT_W'(push.push_a) + CNT_W'(push.push_b);
    assign pop        = out_valid && out_ready;
    assign first_data = push.push_a ? data_a : data_b;

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + n_push - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push_a || push.push_b)
        begin
            entry_reg[wr_ptr_reg] <= first_data;
        end
        if (push.push_a && push.push_b)
        begin
            entry_reg[wr_ptr_reg + PTR_W'(1)] <= data_b;
        end
    end

    // a request may add two rows
    assign room      = (count_reg <= ROOM_MAX);
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire
